@@ src/u8u16_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int OFFSET_WIDTH = 31;   // text offset counter width
    localparam int BAD_OFF_W    = 31;   // width of the reported offset field
    localparam int CP_W         = 21;   // code point width
    localparam int CNT_W        = 3;    // results per item, 0..5

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_2B    = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h000800;
    localparam logic [15:0]     HI_SURR_BASE = 16'hD800;
    localparam logic [15:0]     LO_SURR_BASE = 16'hDC00;

    typedef struct packed {
        logic [1:0]              need;   // continuation bytes still expected
        logic [1:0]              len;    // sequence length minus one
        logic [CP_W-1:0]         pcp;    // code point bits gathered so far
        logic [OFFSET_WIDTH-1:0] start;  // offset of the open sequence's lead
        logic [OFFSET_WIDTH-1:0] pos;    // offset of the next byte
        logic                    drop;   // discarding the rest of the text
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;    // results caused by this item
        logic [CNT_W-1:0]        ndata;  // data bytes among them
        logic [15:0]             unit0;
        logic [15:0]             unit1;
        logic                    bad;
        logic [OFFSET_WIDTH-1:0] bad_at;
        t_state                  nxt;
    } t_dec;

endpackage

@@ src/u8u16_dec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_dec
// Decodes one UTF-8 byte against the sequence state: result count, UTF-16
// code units, error flag and offset, and the state after the item.
// ----------------------------------------------------------------------------
module u8u16_dec (
    input  logic [7:0]         i_byte,
    input  logic               i_eot,
    input  u8u16_pkg::t_state  i_st,
    output u8u16_pkg::t_dec    o_dec
);
    import u8u16_pkg::*;

    logic                    emit;
    logic [CP_W-1:0]         cp;
    logic [CP_W-1:0]         v;
    logic [CP_W-1:0]         vs;
    logic                    bad;
    logic [OFFSET_WIDTH-1:0] bad_at;
    logic                    ok;
    t_state                  st;
    logic [CNT_W-1:0]        ndata;

    always_comb begin
        st     = i_st;
        emit   = 1'b0;
        cp     = '0;
        bad    = 1'b0;
        bad_at = '0;
        ok     = 1'b1;
        v      = {i_st.pcp[CP_W-7:0], i_byte[5:0]};
        vs     = '0;

        if (i_st.need == 2'd0) begin
            if (i_byte inside {[8'h00:8'h7F]}) begin
                emit = 1'b1;
                cp   = {{(CP_W-8){1'b0}}, i_byte};
            end else if (i_byte inside {[8'hC0:8'hDF]}) begin
                st.need  = 2'd1;
                st.len   = 2'd1;
                st.pcp   = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                st.start = i_st.pos;
            end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                st.need  = 2'd2;
                st.len   = 2'd2;
                st.pcp   = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                st.start = i_st.pos;
            end else if (i_byte inside {[8'hF0:8'hF7]}) begin
                st.need  = 2'd3;
                st.len   = 2'd3;
                st.pcp   = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                st.start = i_st.pos;
            end else begin
                bad    = 1'b1;
                bad_at = i_st.pos;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            bad    = 1'b1;
            bad_at = i_st.start;
        end else begin
            st.pcp  = v;
            st.need = i_st.need - 2'd1;
            if (st.need == 2'd0) begin
                // overlong, too large or surrogate
                if (i_st.len == 2'd1 && v < CP_MIN_2B)    ok = 1'b0;
                if (i_st.len == 2'd2 && v < CP_MIN_3B)    ok = 1'b0;
                if (i_st.len == 2'd3 && v < CP_SUPP_BASE) ok = 1'b0;
                if (v > CP_MAX || (v >= CP_SURR_LO && v <= CP_SURR_HI)) ok = 1'b0;
                if (ok) begin
                    emit = 1'b1;
                    cp   = v;
                end else begin
                    bad    = 1'b1;
                    bad_at = i_st.start;
                end
            end
        end

        // text cut short inside a sequence
        if (!bad && i_eot && st.need != 2'd0) begin
            bad    = 1'b1;
            bad_at = st.start;
        end

        if (bad || i_eot || emit) begin
            st.need  = 2'd0;
            st.len   = 2'd0;
            st.pcp   = '0;
            st.start = '0;
        end
        if (bad && !i_eot) st.drop = 1'b1;
        st.pos = i_eot ? '0 : OFFSET_WIDTH'(i_st.pos + 1'b1);

        vs = cp - CP_SUPP_BASE;
        if (!emit || bad) begin
            ndata = '0;
        end else if (cp >= CP_SUPP_BASE) begin
            ndata = CNT_W'(4);
        end else begin
            ndata = CNT_W'(2);
        end

        o_dec.unit0 = (cp >= CP_SUPP_BASE) ? (HI_SURR_BASE | {6'd0, vs[19:10]})
                                           : cp[15:0];
        o_dec.unit1 = LO_SURR_BASE | {6'd0, vs[9:0]};
        o_dec.bad   = bad;
        o_dec.bad_at = bad_at;

        if (i_st.drop) begin
            // discard; the final byte ends the text
            o_dec.cnt   = '0;
            o_dec.ndata = '0;
            o_dec.bad   = 1'b0;
            o_dec.nxt   = i_st;
            if (i_eot) begin
                o_dec.nxt.drop  = 1'b0;
                o_dec.nxt.need  = 2'd0;
                o_dec.nxt.len   = 2'd0;
                o_dec.nxt.pcp   = '0;
                o_dec.nxt.start = '0;
                o_dec.nxt.pos   = '0;
            end else begin
                o_dec.nxt.pos = OFFSET_WIDTH'(i_st.pos + 1'b1);
            end
        end else begin
            o_dec.ndata = ndata;
            o_dec.cnt   = ndata + CNT_W'(bad || i_eot);
            o_dec.nxt   = st;
        end
    end

endmodule

@@ src/utf8_to_utf16_transcoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// An item accepted into the input register is decoded combinationally and
// its results pass through the output register. Throughput: one result per
// cycle from the output register while i_stall is low; an item has 0 to 5
// results, so a byte with two UTF-16 bytes gives 2. Input register and output
// register overlap, so a new item enters while results of the last one wait.
// Reset (synchronous, active low) clears both valids, sequence state, the
// text offset and the byte-order register (little-endian).
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic [30:0] o_bad_offset,
    output logic        o_last
);
    import u8u16_pkg::*;

    logic                 r_be;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eot;
    t_state               r_st;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     n_idx;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    t_status              r_out_status;
    logic [BAD_OFF_W-1:0] r_out_off;
    logic                 r_out_last;

    t_dec                 dec;
    logic                 out_free;
    logic                 emit;
    logic                 consume;
    logic [15:0]          unit;
    logic [7:0]           sel_byte;
    t_status              sel_status;
    logic [BAD_OFF_W-1:0] sel_off;
    logic                 sel_last;

    u8u16_dec u_dec (
        .i_byte (r_in_byte),
        .i_eot  (r_in_eot),
        .i_st   (r_st),
        .o_dec  (dec)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_in_valid && (dec.cnt != '0) && out_free;
    assign sel_last = (r_idx == dec.cnt - CNT_W'(1));
    assign consume  = r_in_valid && ((dec.cnt == '0) || (emit && sel_last));
    assign o_stall  = r_in_valid && !consume;

    always_comb begin
        unit       = r_idx[1] ? dec.unit1 : dec.unit0;
        sel_byte   = '0;
        sel_status = ST_DATA;
        sel_off    = '0;
        if (r_idx < dec.ndata) begin
            // first byte of a unit is the high one in big-endian order
            sel_byte = (r_idx[0] != r_be) ? unit[15:8] : unit[7:0];
        end else if (dec.bad) begin
            sel_status = ST_BAD;
            sel_off    = BAD_OFF_W'(dec.bad_at);
        end else begin
            sel_status = ST_DONE;
        end
        if (consume) begin
            n_idx = '0;
        end else if (emit) begin
            n_idx = r_idx + CNT_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_be        <= 1'b0;
            r_in_valid  <= 1'b0;
            r_st        <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_be <= i_cfg_data;
            if (consume) r_st <= dec.nxt;
            r_idx <= n_idx;
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
            r_in_eot  <= i_end_of_text;
        end
        if (emit) begin
            r_out_byte   <= sel_byte;
            r_out_status <= sel_status;
            r_out_off    <= sel_off;
            r_out_last   <= sel_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_status     = r_out_status;
    assign o_bad_offset = r_out_off;
    assign o_last       = r_out_last;

endmodule

@@ src/u8u16_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_chk
// Port-level checks on the result channel of the transcoder.
// ----------------------------------------------------------------------------
module u8u16_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_status,
    input logic [30:0] o_bad_offset,
    input logic        o_last
);
    import u8u16_pkg::*;

    // hold a stalled item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_status)
            && $stable(o_bad_offset) && $stable(o_last))
        else $error("stalled result changed");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DONE || o_status == ST_BAD) |-> o_last)
        else $error("done or error result not marked last");

    a_data_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_BAD |-> o_bad_offset == '0)
        else $error("offset set on a non-error result");

    a_term_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DATA |-> o_out_byte == 8'd0)
        else $error("byte set on a status result");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_DATA || o_status == ST_DONE || o_status == ST_BAD)
        else $error("undefined status code");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_chk u_chk (.*);
